// ===== hdl/nth_order_difference_stream_defines.svh =====
// Assertion macros shared by the difference stream RTL.
`ifndef NTH_ORDER_DIFFERENCE_STREAM_DEFINES_SVH
`define NTH_ORDER_DIFFERENCE_STREAM_DEFINES_SVH

// Check that cond holds at every clock edge out of reset.
`define NODS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Check that trig implies cond in the same cycle.
`define NODS_ASSERT_IMPLY(lbl, clk, rst_n, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
		else $error(msg);

`endif

// ===== hdl/nods_pkg.sv =====
// Types and constants of the n-th order difference stream.
`default_nettype none
package nods_pkg;

	localparam int MAX_ORDER  = 8;
	localparam int INNER_MAX  = 256;
	localparam int SAMPLE_W   = 32;
	localparam int DIFF_W     = 41;
	localparam int ORDER_W    = 4;
	localparam int LEN_W      = 16;
	localparam int STRIDE_W   = 9;
	localparam int ADDR_W     = $clog2(INNER_MAX);
	localparam int LVL_W      = $clog2(MAX_ORDER + 1);
	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 16;
	localparam int OUT_TDATA_W = ((DIFF_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIFF_ORDER   = 2'd0,
		REG_LINE_LENGTH  = 2'd1,
		REG_INNER_STRIDE = 2'd2
	} nods_reg_t;

	// Control that travels with each word down the cell chain.
	typedef struct packed {
		logic              valid;
		logic              emit;  // word yields a result
		logic              last;  // final result of an outer block
		logic [LVL_W-1:0]  lvl;   // min(axis position, order)
		logic [ADDR_W-1:0] addr;  // inner position
	} nods_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/nods_front.sv =====
// Entry stage: position counters, clamping of the registers, word tagging.
`default_nettype none
module nods_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [nods_pkg::ORDER_W-1:0]        diff_order,
	input  wire logic [nods_pkg::LEN_W-1:0]          line_length,
	input  wire logic [nods_pkg::STRIDE_W-1:0]       inner_stride,
	input  wire logic signed [nods_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                restart,
	input  wire logic                                accept,
	output logic                                     emit_now,
	output nods_pkg::nods_ctl_t                      ctl_s1,
	output logic signed [nods_pkg::DIFF_W-1:0]       v_s1
);

	logic [nods_pkg::ADDR_W-1:0]   inner_q;
	logic [nods_pkg::LEN_W-1:0]    axis_q;
	logic [nods_pkg::LVL_W-1:0]    ord;
	logic [nods_pkg::LEN_W-1:0]    len;
	logic [nods_pkg::STRIDE_W-1:0] str;
	logic [nods_pkg::ADDR_W-1:0]   a_base, a;
	logic [nods_pkg::LEN_W-1:0]    i_base, i;
	logic [nods_pkg::STRIDE_W-1:0] a_inc;
	logic [nods_pkg::LEN_W:0]      i_inc;
	logic                          last;
	logic [nods_pkg::LVL_W-1:0]    lvl;

	always_comb begin
		if (diff_order == '0) begin
			ord = nods_pkg::LVL_W'(1);
		end else if (diff_order > nods_pkg::ORDER_W'(nods_pkg::MAX_ORDER)) begin
			ord = nods_pkg::LVL_W'(nods_pkg::MAX_ORDER);
		end else begin
			ord = nods_pkg::LVL_W'(diff_order);
		end
		len = (line_length == '0) ? nods_pkg::LEN_W'(1) : line_length;
		if (inner_stride == '0) begin
			str = nods_pkg::STRIDE_W'(1);
		end else if (inner_stride > nods_pkg::STRIDE_W'(nods_pkg::INNER_MAX)) begin
			str = nods_pkg::STRIDE_W'(nods_pkg::INNER_MAX);
		end else begin
			str = inner_stride;
		end

		// restart rewinds; a counter past its bound after a register change reads as 0
		a_base = restart ? '0 : inner_q;
		i_base = restart ? '0 : axis_q;
		a = (nods_pkg::STRIDE_W'(a_base) >= str) ? '0 : a_base;
		i = (i_base >= len) ? '0 : i_base;

		a_inc = nods_pkg::STRIDE_W'(a) + nods_pkg::STRIDE_W'(1);
		i_inc = (nods_pkg::LEN_W + 1)'(i) + (nods_pkg::LEN_W + 1)'(1);

		emit_now = (i >= nods_pkg::LEN_W'(ord));
		lvl = emit_now ? ord : nods_pkg::LVL_W'(i);
		last = (i == len - nods_pkg::LEN_W'(1)) &&
			(nods_pkg::STRIDE_W'(a) == str - nods_pkg::STRIDE_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			axis_q  <= '0;
			ctl_s1  <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.emit <= emit_now;
				ctl_s1.last <= last;
				ctl_s1.lvl  <= lvl;
				ctl_s1.addr <= a;
				if (a_inc >= str) begin
					inner_q <= '0;
					axis_q  <= (i_inc >= (nods_pkg::LEN_W + 1)'(len)) ?
						'0 : nods_pkg::LEN_W'(i_inc);
				end else begin
					inner_q <= nods_pkg::ADDR_W'(a_inc);
					axis_q  <= i;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1 <= nods_pkg::DIFF_W'(sample);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/nods_cell.sv =====
// One difference stage: a line of delayed inputs and one subtractor.
`default_nettype none
module nods_cell (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [nods_pkg::LVL_W-1:0]         stage_idx,
	input  wire nods_pkg::nods_ctl_t                ctl_in,
	input  wire logic signed [nods_pkg::DIFF_W-1:0] v_in,
	output nods_pkg::nods_ctl_t                     ctl_out,
	output logic signed [nods_pkg::DIFF_W-1:0]      v_out
);

	logic signed [nods_pkg::DIFF_W-1:0] line_mem [nods_pkg::INNER_MAX];
	logic signed [nods_pkg::DIFF_W-1:0] prev_q;
	logic signed [nods_pkg::DIFF_W-1:0] v_s1;
	nods_pkg::nods_ctl_t                ctl_s1;
	logic                               sub_s1;
	logic                               wr;
	logic                               sub;

	// store when this stage lies within the word's cascade
	assign sub = (stage_idx < ctl_in.lvl);
	assign wr  = ctl_in.valid && (sub || ((stage_idx == ctl_in.lvl) && !ctl_in.emit));

	// read-before-write: prev_q takes the old entry
	always_ff @(posedge clk) begin
		prev_q <= line_mem[ctl_in.addr];
		if (wr) begin
			line_mem[ctl_in.addr] <= v_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_out <= '0;
		end else begin
			ctl_s1  <= ctl_in;
			ctl_out <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		v_s1   <= v_in;
		sub_s1 <= sub;
		v_out  <= sub_s1 ? (v_s1 - prev_q) : v_s1;
	end

endmodule
`default_nettype wire

// ===== hdl/nods_fifo.sv =====
// Result queue between the cell chain and the output port.
`default_nettype none
module nods_fifo (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	input  wire logic                               push_last,
	input  wire logic signed [nods_pkg::DIFF_W-1:0] push_diff,
	input  wire logic                               pop,
	output logic                                    out_valid,
	output logic                                    out_last,
	output logic signed [nods_pkg::DIFF_W-1:0]      out_diff,
	output logic [nods_pkg::CNT_W-1:0]              count
);

	logic [nods_pkg::DIFF_W:0]    entry_q [nods_pkg::FIFO_DEPTH];
	logic [nods_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [nods_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [nods_pkg::CNT_W-1:0]   count_q;
	logic                         do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign out_valid = (count_q != '0);
	assign out_last  = entry_q[rd_ptr_q][nods_pkg::DIFF_W];
	assign out_diff  = entry_q[rd_ptr_q][nods_pkg::DIFF_W-1:0];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= {push_last, push_diff};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + nods_pkg::FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + nods_pkg::FIFO_AW'(1);
			end
			count_q <= count_q + nods_pkg::CNT_W'(push) - nods_pkg::CNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/nth_order_difference_stream.sv =====
// Top level of the n-th order difference stream.
//
//  channel   | direction | handshake                   | word contents (low bit up)
//  ----------+-----------+-----------------------------+--------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata: sample[31:0]; tuser: restart
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: difference[40:0], zero pad;
//            |           |                             | tlast: block_last
//  cfg       | in        | cfg_we (no wait)            | cfg_index, cfg_data[15:0]
//
// One input word per cycle while s_axis_tready is high; a word's result is
// written into the result queue after the entry register and two registers
// per cell (the delay-line read and the subtract) and can leave on m_axis at
// the earliest in the cycle after the write. The chain never stalls.
// The result queue holds FIFO_DEPTH results; a credit count of results in
// flight or queued gates s_axis_tready, so the queue never overflows while
// a result waits. Reset clears counters, valid bits, queue pointers and
// loads diff_order 1, line_length 2, inner_stride 1; delay lines need no clear.
`default_nettype none
`include "nth_order_difference_stream_defines.svh"
module nth_order_difference_stream (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	input  wire logic signed [nods_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // sample
	input  wire logic                                   s_axis_tuser,  // restart
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	output logic [nods_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,  // difference, zero pad
	output logic                                        m_axis_tlast,
	input  wire logic                                   cfg_we,
	input  wire logic [nods_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [nods_pkg::CFG_W-1:0]             cfg_data
);

	logic [nods_pkg::ORDER_W-1:0]  diff_order_q;
	logic [nods_pkg::LEN_W-1:0]    line_length_q;
	logic [nods_pkg::STRIDE_W-1:0] inner_stride_q;
	logic [nods_pkg::CNT_W-1:0]    credit_q;
	logic [nods_pkg::CNT_W-1:0]    fifo_count;
	logic                          in_accept;
	logic                          out_accept;
	logic                          emit_now;
	logic                          fifo_push;
	logic signed [nods_pkg::DIFF_W-1:0] out_diff;

	nods_pkg::nods_ctl_t                chain_ctl [nods_pkg::MAX_ORDER + 1];
	logic signed [nods_pkg::DIFF_W-1:0] chain_v   [nods_pkg::MAX_ORDER + 1];

	// configuration: take the write at once, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_order_q   <= nods_pkg::ORDER_W'(1);
			line_length_q  <= nods_pkg::LEN_W'(2);
			inner_stride_q <= nods_pkg::STRIDE_W'(1);
		end else if (cfg_we) begin
			case (nods_pkg::nods_reg_t'(cfg_index))
				nods_pkg::REG_DIFF_ORDER: begin
					diff_order_q <= cfg_data[nods_pkg::ORDER_W-1:0];
				end
				nods_pkg::REG_LINE_LENGTH: begin
					line_length_q <= cfg_data[nods_pkg::LEN_W-1:0];
				end
				nods_pkg::REG_INNER_STRIDE: begin
					inner_stride_q <= cfg_data[nods_pkg::STRIDE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// hold input while every queue slot is promised to a word in flight
	assign s_axis_tready = (credit_q < nods_pkg::CNT_W'(nods_pkg::FIFO_DEPTH));
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_accept    = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + nods_pkg::CNT_W'(in_accept && emit_now)
				- nods_pkg::CNT_W'(out_accept);
		end
	end

	nods_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.diff_order   (diff_order_q),
		.line_length  (line_length_q),
		.inner_stride (inner_stride_q),
		.sample       (s_axis_tdata),
		.restart      (s_axis_tuser),
		.accept       (in_accept),
		.emit_now     (emit_now),
		.ctl_s1       (chain_ctl[0]),
		.v_s1         (chain_v[0])
	);

	// each word passes each cell through its two registers; cell k is stage k of the cascade
	for (genvar k = 0; k < nods_pkg::MAX_ORDER; k++) begin : g_cell
		nods_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_idx (nods_pkg::LVL_W'(k)),
			.ctl_in    (chain_ctl[k]),
			.v_in      (chain_v[k]),
			.ctl_out   (chain_ctl[k + 1]),
			.v_out     (chain_v[k + 1])
		);
	end

	// drop words that yield no result, queue the rest
	assign fifo_push = chain_ctl[nods_pkg::MAX_ORDER].valid &&
		chain_ctl[nods_pkg::MAX_ORDER].emit;

	nods_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_last (chain_ctl[nods_pkg::MAX_ORDER].last),
		.push_diff (chain_v[nods_pkg::MAX_ORDER]),
		.pop       (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_last  (m_axis_tlast),
		.out_diff  (out_diff),
		.count     (fifo_count)
	);

	assign m_axis_tdata = nods_pkg::OUT_TDATA_W'(unsigned'(out_diff));

	`NODS_ASSERT_ALWAYS(a_credit_bound, clk, arst_n,
		credit_q <= nods_pkg::CNT_W'(nods_pkg::FIFO_DEPTH), "credit count above queue depth")
	`NODS_ASSERT_ALWAYS(a_queue_in_credit, clk, arst_n,
		fifo_count <= credit_q, "queued results exceed outstanding credits")
	`NODS_ASSERT_IMPLY(a_no_overflow, clk, arst_n, fifo_push,
		fifo_count < nods_pkg::CNT_W'(nods_pkg::FIFO_DEPTH) || m_axis_tready,
		"result pushed into a full queue")

endmodule
`default_nettype wire

// ===== tb/nth_order_difference_stream_test.sv =====
// Self-checking testbench for the n-th order difference stream.
module nth_order_difference_stream_test;
	timeunit 1ns;
	timeprecision 1ps;

	import nods_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 11;
	// Entry register, two registers per cell and the queue register, taken three times over.
	localparam int SETTLE_CYCLES  = 3 * (2 * MAX_ORDER + 2);
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 32'h7FFF_FFFF;
	localparam logic [SAMPLE_W-1:0]  SAMPLE_MIN = 32'h8000_0000;
	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [DIFF_W-1:0] difference;
		logic              block_last;
	} diff_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [SAMPLE_W-1:0]         s_axis_tdata = '0;  // sample
	logic                        s_axis_tuser = 1'b0;  // restart
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]      m_axis_tdata;  // difference, zero pad
	logic                        m_axis_tlast;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]            cfg_data = '0;

	int send_gap_pct = 0;
	int sink_stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// Shadow of the block: registers as written, position counters, delay lines.
	logic [ORDER_W-1:0]  order_reg;
	logic [LEN_W-1:0]    length_reg;
	logic [STRIDE_W-1:0] stride_reg;
	int                  inner_pos;
	int                  axis_pos;
	logic [DIFF_W-1:0]   delay_line [0:MAX_ORDER*INNER_MAX-1];

	// Differences still owed by the block, oldest first.
	diff_result_t expected_results[$];

	nth_order_difference_stream i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Advance the shadow by one accepted word; queue the difference it yields.
	function automatic void step_difference(input logic [SAMPLE_W-1:0] smp,
			input logic restart);
		int ord, len, str, a, i, k;
		logic [DIFF_W-1:0] v, prev;
		diff_result_t res;
		// Clamp the registers to the ranges the block can honor.
		ord = (order_reg == 0) ? 1 : ((order_reg > MAX_ORDER) ? MAX_ORDER : order_reg);
		str = (stride_reg == 0) ? 1 : ((stride_reg > INNER_MAX) ? INNER_MAX : stride_reg);
		len = (length_reg == 0) ? 1 : length_reg;
		if (restart) begin
			inner_pos = 0;
			axis_pos = 0;
		end
		// A register change may leave a counter past its bound: fold it to zero.
		if (inner_pos >= str) inner_pos = 0;
		if (axis_pos >= len) axis_pos = 0;
		a = inner_pos;
		i = axis_pos;
		v = {{(DIFF_W - SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
		// Stage k only runs once axis position reaches k; at i == k it just fills.
		for (k = 0; k < ord && k <= i; k++) begin
			prev = delay_line[k * INNER_MAX + a];
			delay_line[k * INNER_MAX + a] = v;
			if (k < i) v = v - prev;
		end
		inner_pos = a + 1;
		if (inner_pos >= str) begin
			inner_pos = 0;
			axis_pos = i + 1;
			if (axis_pos >= len) axis_pos = 0;
		end
		if (i >= ord) begin
			res.difference = v;
			res.block_last = (i == len - 1) && (a == str - 1);
			expected_results.push_back(res);
		end
	endfunction

	// Receiver: stall at the current rate.
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	// Check every accepted result word against the oldest expectation.
	always @(posedge clk) begin
		diff_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result word tdata=%h tlast=%b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[DIFF_W-1:0] !== want.difference)
					report_mismatch($sformatf("difference %h, expected %h",
						m_axis_tdata[DIFF_W-1:0], want.difference));
				if (m_axis_tdata[OUT_TDATA_W-1:DIFF_W] !== '0)
					report_mismatch($sformatf("tdata pad bits %h, expected zero",
						m_axis_tdata[OUT_TDATA_W-1:DIFF_W]));
				if (m_axis_tlast !== want.block_last)
					report_mismatch($sformatf("block_last %b, expected %b",
						m_axis_tlast, want.block_last));
			end
		end
	end

	// Watchdog: end the run once words stop moving on both sides for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_gap_pct = 0;
				sink_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_gap_pct = 55;
				sink_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_gap_pct = 0;
				sink_stall_pct = 55;
			end
			default: begin
				send_gap_pct = 11;
				sink_stall_pct = 11;
			end
		endcase
	endtask

	// Offer one word, idling first at the current rate; hold it until taken.
	task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic restart);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tuser <= restart;
		do @(posedge clk); while (!s_axis_tready);
		step_difference(smp, restart);
	endtask

	// Drop valid, wait for every owed result, then let the chain run dry.
	task automatic drain_results(input int settle);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Drive cfg_we high with the write and wait for a clock edge; leaves it high so back-to-back writes work.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_DIFF_ORDER:   order_reg = val[ORDER_W-1:0];
			REG_LINE_LENGTH:  length_reg = val[LEN_W-1:0];
			REG_INNER_STRIDE: stride_reg = val[STRIDE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input int ord, input int len, input int str,
			input bit poke_spare = 1'b0);
		drain_results(SETTLE_CYCLES);
		if (poke_spare) write_reg(REG_SPARE, '1);
		write_reg(REG_DIFF_ORDER, CFG_W'(ord));
		write_reg(REG_LINE_LENGTH, CFG_W'(len));
		write_reg(REG_INNER_STRIDE, CFG_W'(str));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_W'($urandom_range(0, 31)) - SAMPLE_W'(16);
			default: return $urandom();
		endcase
	endfunction

	// Reset values: first order, line of two, stride one. Full-scale pairs and
	// a restart that lands on axis position one.
	task automatic test_reset_defaults();
		send_word(SAMPLE_MAX, 1'b1);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		send_word(SAMPLE_MAX, 1'b0);
	endtask

	// Eighth order over alternating full-scale words: the widest difference.
	task automatic test_full_scale_order8();
		int n;
		apply_config(MAX_ORDER, MAX_ORDER + 1, 1);
		for (n = 0; n <= MAX_ORDER; n++)
			send_word(n[0] ? SAMPLE_MAX : SAMPLE_MIN, n == 0);
	endtask

	// Zero registers act as their minimum, oversized ones as their maximum;
	// a line no longer than the order yields nothing, and neither does the
	// spare index.
	task automatic test_register_limits();
		apply_config(0, 0, 0, 1'b1);
		send_word(random_sample(), 1'b1);
		send_word(random_sample(), 1'b0);
		apply_config(15, MAX_ORDER, 511);
		send_word(random_sample(), 1'b1);
		send_word(random_sample(), 1'b0);
	endtask

	// Stop part way into a line, shrink both bounds below the counters and
	// carry on without a restart: both counters fold back to zero.
	task automatic test_position_wrap();
		int n;
		set_idling(IDLE_BOTH);
		apply_config(2, 6, 2);
		// Axes zero to three in full, then the first inner word of axis four.
		for (n = 0; n < 9; n++) send_word(random_sample(), n == 0);
		apply_config(2, 3, 1);
		for (n = 0; n < 4; n++) send_word(random_sample(), 1'b0);
	endtask

	// Phases of random tensors, each under its own registers and idling.
	task automatic test_random_tensors();
		int phase, n, count, ord, len, str;
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				3: begin
					// Widest stride: one whole tensor of first order.
					ord = 1;
					len = 2;
					str = INNER_MAX;
					count = 2 * INNER_MAX;
				end
				7: begin
					// Longest line; the tensor never reaches its end.
					ord = MAX_ORDER;
					len = 65535;
					str = 1;
					count = 60;
				end
				default: begin
					ord = $urandom_range(1, MAX_ORDER);
					str = $urandom_range(1, 5);
					len = $urandom_range(ord, ord + 5);
					if (len < 2) len = 2;
					count = $urandom_range(10, 25);
				end
			endcase
			apply_config(ord, len, str);
			set_idling(idle_mode_t'(phase % 4));
			for (n = 0; n < count; n++) begin
				// Hold off the sender until the result side is empty.
				if ((phase == 0 && n == 8) || $urandom_range(0, 99) == 0)
					drain_results(1);
				// Restart on the first word; a few stray restarts mid tensor.
				send_word(random_sample(), n == 0 || $urandom_range(0, 99) < 3);
			end
		end
	endtask

	initial begin
		// Shadow reset state, matching the block's reset values.
		order_reg = 1;
		length_reg = 2;
		stride_reg = 1;
		inner_pos = 0;
		axis_pos = 0;
		for (int e = 0; e < MAX_ORDER * INNER_MAX; e++) delay_line[e] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_full_scale_order8();
		test_register_limits();
		test_position_wrap();
		test_random_tensors();
		drain_results(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
